// ===== rtl/rgi_pkg.sv =====
`default_nettype none
package rgi_pkg;
    localparam int MAX_POINTS_X = 64;
    localparam int MAX_POINTS_Y = 64;
    localparam int NODE_DEPTH   = MAX_POINTS_X * MAX_POINTS_Y;
    localparam int XW           = $clog2(MAX_POINTS_X);
    localparam int YW           = $clog2(MAX_POINTS_Y);
    localparam int NW           = $clog2(NODE_DEPTH);
    localparam int IW           = (XW > YW) ? XW : YW;
    localparam int CNTW         = IW + 1;
    localparam int FRAC_BITS    = 30;
    localparam int CFG_W        = 7;

    typedef enum logic [1:0] {
        REQ_LOAD_X    = 2'd0,
        REQ_LOAD_Y    = 2'd1,
        REQ_LOAD_NODE = 2'd2,
        REQ_QUERY     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        CFG_POINTS_X = 2'd0,
        CFG_POINTS_Y = 2'd1,
        CFG_DIMS     = 2'd2,
        CFG_NONE     = 2'd3
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_CK0, S_CKN, S_SCAN, S_DIV, S_AXDONE,
        S_NRD, S_NCK, S_LMUL, S_LADD, S_OUT
    } t_state;

    // Clamp a point count into 1..maxn.
    function automatic logic [CNTW-1:0] eff_count(input logic [CFG_W-1:0] n, input int maxn);
        logic [CFG_W-1:0] m;
        begin
            m = CFG_W'(maxn);
            if (n == '0) begin
                eff_count = CNTW'(1);
            end else if (n > m) begin
                eff_count = CNTW'(maxn);
            end else begin
                eff_count = CNTW'(n);
            end
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        begin
            if (v > 34'sd2147483647) begin
                sat32 = 32'sh7fffffff;
            end else if (v < -34'sd2147483648) begin
                sat32 = 32'sh80000000;
            end else begin
                sat32 = v[31:0];
            end
        end
    endfunction
endpackage
`default_nettype wire

// ===== rtl/rgi_ram.sv =====
`default_nettype none
module rgi_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/rgi_div.sv =====
`default_nettype none
module rgi_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [rgi_pkg::FRAC_BITS-1:0] o_quot
);
    import rgi_pkg::*;

    logic                 r_busy;
    logic [4:0]           r_cnt;
    logic [31:0]          r_rem;
    logic [31:0]          r_den;
    logic [FRAC_BITS-1:0] r_quot;
    logic                 r_done;
    logic [32:0]          sh;

    // One restoring step per cycle: shift, trial subtract.
    assign sh = {r_rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (sh >= {1'b0, r_den}) begin
                    r_rem  <= 32'(sh - {1'b0, r_den});
                    r_quot <= {r_quot[FRAC_BITS-2:0], 1'b1};
                end else begin
                    r_rem  <= sh[31:0];
                    r_quot <= {r_quot[FRAC_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== rtl/rectilinear_grid_interpolator_unit.sv =====
`default_nettype none
// Bilinear interpolator over a rectilinear grid. Load words write X or Y
// coordinates or node values into on-chip memories and give no result; a
// query word gives one saturated Q16.16 value. A query is accepted, then runs
// a memory scan on each axis in use, plus a divide for each axis whose point
// falls strictly inside the grid (one quotient bit a cycle in the shared
// divider), then node reads (four in 2-D, two in 1-D), lerp steps (three in
// 2-D, one in 1-D; one multiply and one round-and-add a step) and a load of
// the output register.
// The scan reads one coordinate a cycle from a single-port-read memory and
// stops at the first coordinate above the point. New words are held off while
// a query runs; a finished result waits in the output register without
// blocking the next word. Write configuration only when the block is idle.
module rectilinear_grid_interpolator_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [11:0] i_load_index,
    input  wire logic signed [31:0] i_load_data,
    input  wire logic signed [31:0] i_point_x,
    input  wire logic signed [31:0] i_point_y,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_value,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [rgi_pkg::CFG_W-1:0] i_cfg_data
);
    import rgi_pkg::*;

    t_state r_state, n_state;

    // configuration
    logic [CFG_W-1:0] r_points_x, r_points_y;
    logic [1:0]       r_dims;

    // query context
    logic signed [31:0] r_pt_x, r_pt_y, n_pt_x, n_pt_y;
    logic [CNTW-1:0]    r_px, r_py, n_px, n_py;
    logic               r_dims2, n_dims2;
    logic               r_axis, n_axis;
    logic [IW-1:0]      r_k, n_k, r_lo, n_lo, r_hi, n_hi;
    logic signed [31:0] r_prev, n_prev;
    logic [FRAC_BITS-1:0] r_t, n_t, r_tx, n_tx, r_ty, n_ty;
    logic [IW-1:0]      r_ix1, n_ix1, r_ix2, n_ix2, r_iy1, n_iy1, r_iy2, n_iy2;
    logic [1:0]         r_nsel, n_nsel, r_step, n_step;
    logic signed [31:0] r_v [4];
    logic signed [31:0] n_v [4];
    logic [61:0]        r_prod, n_prod;
    logic               r_dneg, n_dneg;
    logic signed [31:0] r_a, n_a, r_acc0, n_acc0, r_acc1, n_acc1;
    logic               r_ovalid, n_ovalid;
    logic signed [31:0] r_out, n_out;

    // memory and divider hookup
    logic [IW-1:0]  rd_addr;
    logic [NW-1:0]  node_addr;
    logic [31:0]    x_rd, y_rd, v_rd;
    logic           div_start, div_done;
    logic [31:0]    div_num, div_den;
    logic [FRAC_BITS-1:0] div_q;

    logic               accept;
    logic signed [31:0] c_data, p_cur;
    logic [CNTW-1:0]    n_cur;
    logic [IW-1:0]      last;
    logic signed [31:0] op_a, op_b;
    logic [FRAC_BITS-1:0] op_t;
    logic signed [32:0] diff;
    logic [31:0]        mag;
    logic [32:0]        rnd;
    logic signed [33:0] lres;
    logic signed [31:0] lsat;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_value = r_out;

    // current axis view
    assign c_data = r_axis ? $signed(y_rd) : $signed(x_rd);
    assign p_cur  = r_axis ? r_pt_y : r_pt_x;
    assign n_cur  = r_axis ? r_py : r_px;
    assign last   = IW'(n_cur - CNTW'(1));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_x <= CFG_W'(1);
            r_points_y <= CFG_W'(1);
            r_dims     <= 2'd1;
        end else if (i_cfg_we) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_POINTS_X: r_points_x <= i_cfg_data;
                CFG_POINTS_Y: r_points_y <= i_cfg_data;
                CFG_DIMS:     r_dims     <= i_cfg_data[1:0];
                CFG_NONE:     ;
            endcase
        end
    end

    rgi_ram #(.DEPTH(MAX_POINTS_X), .WIDTH(32)) u_xram (
        .i_clk    (i_clk),
        .i_we     (accept && t_req'(i_req_type) == REQ_LOAD_X
                   && i_load_index < 12'(MAX_POINTS_X)),
        .i_wr_addr(i_load_index[XW-1:0]),
        .i_wr_data(i_load_data),
        .i_rd_addr(rd_addr[XW-1:0]),
        .o_rd_data(x_rd)
    );

    rgi_ram #(.DEPTH(MAX_POINTS_Y), .WIDTH(32)) u_yram (
        .i_clk    (i_clk),
        .i_we     (accept && t_req'(i_req_type) == REQ_LOAD_Y
                   && i_load_index < 12'(MAX_POINTS_Y)),
        .i_wr_addr(i_load_index[YW-1:0]),
        .i_wr_data(i_load_data),
        .i_rd_addr(rd_addr[YW-1:0]),
        .o_rd_data(y_rd)
    );

    rgi_ram #(.DEPTH(NODE_DEPTH), .WIDTH(32)) u_vram (
        .i_clk    (i_clk),
        .i_we     (accept && t_req'(i_req_type) == REQ_LOAD_NODE
                   && 13'(i_load_index) < 13'(NODE_DEPTH)),
        .i_wr_addr(i_load_index[NW-1:0]),
        .i_wr_data(i_load_data),
        .i_rd_addr(node_addr),
        .o_rd_data(v_rd)
    );

    rgi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quot (div_q)
    );

    // node address: i + j * points_x
    always_comb begin
        node_addr = NW'(r_nsel[0] ? r_ix2 : r_ix1)
                  + NW'(NW'(r_nsel[1] ? r_iy2 : r_iy1) * NW'(r_px));
    end

    // lerp operands by step: in 2-D two row lerps along X, then one along Y; in 1-D one along X
    always_comb begin
        unique case (r_step)
            2'd0: begin op_a = r_v[0]; op_b = r_v[1]; op_t = r_tx; end
            2'd1: begin op_a = r_v[2]; op_b = r_v[3]; op_t = r_tx; end
            default: begin op_a = r_acc0; op_b = r_acc1; op_t = r_ty; end
        endcase
        diff = 33'(op_b) - 33'(op_a);
        mag  = diff[32] ? 32'(-diff) : diff[31:0];
        // round to nearest, ties away from zero, on the magnitude
        rnd  = 33'((r_prod + 62'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
        lres = r_dneg ? (34'(r_a) - 34'(rnd)) : (34'(r_a) + 34'(rnd));
        lsat = sat32(lres);
    end

    always_comb begin
        n_state  = r_state;
        n_pt_x   = r_pt_x;   n_pt_y = r_pt_y;
        n_px     = r_px;     n_py   = r_py;
        n_dims2  = r_dims2;  n_axis = r_axis;
        n_k      = r_k;      n_lo   = r_lo;   n_hi = r_hi;
        n_prev   = r_prev;   n_t    = r_t;
        n_tx     = r_tx;     n_ty   = r_ty;
        n_ix1    = r_ix1;    n_ix2  = r_ix2;
        n_iy1    = r_iy1;    n_iy2  = r_iy2;
        n_nsel   = r_nsel;   n_step = r_step;
        n_v      = r_v;
        n_prod   = r_prod;   n_dneg = r_dneg; n_a = r_a;
        n_acc0   = r_acc0;   n_acc1 = r_acc1;
        n_ovalid = r_ovalid; n_out  = r_out;
        rd_addr  = '0;
        div_start = 1'b0;
        div_num  = 32'(p_cur - r_prev);
        div_den  = 32'(c_data - r_prev);

        // drop the output word once taken
        if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept && t_req'(i_req_type) == REQ_QUERY) begin
                    n_pt_x  = i_point_x;
                    n_pt_y  = i_point_y;
                    n_px    = eff_count(r_points_x, MAX_POINTS_X);
                    n_py    = eff_count(r_points_y, MAX_POINTS_Y);
                    n_dims2 = (r_dims == 2'd2);
                    n_axis  = 1'b0;
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                rd_addr = '0;
                n_state = S_CK0;
            end
            S_CK0: begin
                n_prev  = c_data;
                rd_addr = last;
                n_state = S_CKN;
            end
            S_CKN: begin
                rd_addr = IW'(1);
                if (p_cur <= r_prev) begin
                    n_lo = '0; n_hi = '0; n_t = '0;
                    n_state = S_AXDONE;
                end else if (p_cur >= c_data) begin
                    n_lo = last; n_hi = last; n_t = '0;
                    n_state = S_AXDONE;
                end else begin
                    n_k     = IW'(1);
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                rd_addr = r_k + IW'(1);
                if (p_cur < c_data || r_k == last) begin
                    n_lo = r_k - IW'(1);
                    n_hi = r_k;
                    if (c_data <= r_prev || p_cur < r_prev) begin
                        n_t     = '0;
                        n_state = S_AXDONE;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_DIV;
                    end
                end else begin
                    n_prev = c_data;
                    n_k    = r_k + IW'(1);
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_t     = div_q;
                    n_state = S_AXDONE;
                end
            end
            S_AXDONE: begin
                n_nsel = '0;
                if (!r_axis) begin
                    n_ix1 = r_lo; n_ix2 = r_hi; n_tx = r_t;
                    if (r_dims2) begin
                        n_axis  = 1'b1;
                        n_state = S_RD0;
                    end else begin
                        n_iy1 = '0; n_iy2 = '0; n_ty = '0;
                        n_state = S_NRD;
                    end
                end else begin
                    n_iy1 = r_lo; n_iy2 = r_hi; n_ty = r_t;
                    n_state = S_NRD;
                end
            end
            S_NRD: begin
                n_state = S_NCK;
            end
            S_NCK: begin
                n_v[r_nsel] = $signed(v_rd);
                if (r_nsel == (r_dims2 ? 2'd3 : 2'd1)) begin
                    n_step  = 2'd0;
                    n_state = S_LMUL;
                end else begin
                    n_nsel  = r_nsel + 2'd1;
                    n_state = S_NRD;
                end
            end
            S_LMUL: begin
                n_prod  = 62'(mag) * 62'(op_t);
                n_dneg  = diff[32];
                n_a     = op_a;
                n_state = S_LADD;
            end
            S_LADD: begin
                priority if (r_step == 2'd0 && r_dims2) begin
                    n_acc0  = lsat;
                    n_step  = 2'd1;
                    n_state = S_LMUL;
                end else if (r_step == 2'd1) begin
                    n_acc1  = lsat;
                    n_step  = 2'd2;
                    n_state = S_LMUL;
                end else begin
                    n_acc0  = lsat;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (!r_ovalid || !i_stall) begin
                    n_out    = r_acc0;
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pt_x <= n_pt_x;  r_pt_y <= n_pt_y;
        r_px   <= n_px;    r_py   <= n_py;
        r_dims2 <= n_dims2; r_axis <= n_axis;
        r_k    <= n_k;     r_lo   <= n_lo;   r_hi <= n_hi;
        r_prev <= n_prev;  r_t    <= n_t;
        r_tx   <= n_tx;    r_ty   <= n_ty;
        r_ix1  <= n_ix1;   r_ix2  <= n_ix2;
        r_iy1  <= n_iy1;   r_iy2  <= n_iy2;
        r_nsel <= n_nsel;  r_step <= n_step;
        r_v    <= n_v;
        r_prod <= n_prod;  r_dneg <= n_dneg; r_a <= n_a;
        r_acc0 <= n_acc0;  r_acc1 <= n_acc1;
        r_out  <= n_out;
    end

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> (CNTW'(r_k) < n_cur && r_k != '0))
        else $error("scan index outside the grid");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> r_state == S_DIV)
        else $error("divider finished outside the divide state");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && (!r_ovalid || !i_stall)) |=> (r_ovalid && r_state == S_IDLE))
        else $error("result not presented");
endmodule
`default_nettype wire
